/* rtl/cc_pkg.sv */
package cc_pkg;

	localparam int unsigned NUM_DBL_ROUNDS = 10;
	localparam int unsigned NUM_ROUNDS     = 2 * NUM_DBL_ROUNDS;
	localparam int unsigned ROUND_W        = $clog2(NUM_ROUNDS);
	localparam int unsigned DEF_QUEUE_DEPTH = 4;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	localparam logic [5:0] ROT_A = 6'd16;
	localparam logic [5:0] ROT_B = 6'd12;
	localparam logic [5:0] ROT_C = 6'd8;
	localparam logic [5:0] ROT_D = 6'd7;

	typedef enum logic [2:0] {
		REG_KEY0     = 3'd0,
		REG_KEY1     = 3'd1,
		REG_KEY2     = 3'd2,
		REG_KEY3     = 3'd3,
		REG_NONCE_LO = 3'd4,
		REG_NONCE_HI = 3'd5
	} cc_reg_t;

	typedef logic [15:0][31:0] cc_state_t;
	typedef logic [7:0][31:0]  cc_key_t;
	typedef logic [2:0][31:0]  cc_nonce_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cc_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] counter;
	} cc_blk_req_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [5:0] s);
		rotl32 = (v << s) | (v >> (6'd32 - s));
	endfunction

endpackage

/* rtl/cc_front.sv */
module cc_front #(
	parameter int unsigned DEPTH = cc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cc_pkg::cc_item_t  wr_item,
	output logic              rd_valid,
	output cc_pkg::cc_item_t  rd_item,
	input  logic              rd_pop
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cc_pkg::cc_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = push && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cc_core.sv */
module cc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  cc_pkg::cc_blk_req_t blk_req,
	input  cc_pkg::cc_key_t     key,
	input  cc_pkg::cc_nonce_t   nonce,
	output logic                done,
	output cc_pkg::cc_state_t   ks_block
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_FIN  = 3'b100
	} core_state_t;

	core_state_t               state_q;
	cc_pkg::cc_state_t         w_q;
	cc_pkg::cc_state_t         init_q;
	cc_pkg::cc_state_t         w_step;
	cc_pkg::cc_state_t         w_init;
	logic [cc_pkg::ROUND_W-1:0] round_q;
	logic [1:0]                sub_q;
	logic                      done_q;

	assign done     = done_q;
	assign ks_block = w_q;

	always_comb begin
		w_init[0]  = cc_pkg::SIGMA0;
		w_init[1]  = cc_pkg::SIGMA1;
		w_init[2]  = cc_pkg::SIGMA2;
		w_init[3]  = cc_pkg::SIGMA3;
		for (int k = 0; k < 8; k++) begin
			w_init[4 + k] = key[k];
		end
		w_init[12] = blk_req.counter;
		w_init[13] = nonce[0];
		w_init[14] = nonce[1];
		w_init[15] = nonce[2];
	end

	// Four quarter rounds side by side; one add, xor and rotate each per cycle.
	always_comb begin
		logic [1:0]  jj;
		logic [1:0]  diag;
		logic [3:0]  ia, ib, ic, id;
		logic [31:0] t;
		w_step = w_q;
		diag   = {1'b0, round_q[0]};
		for (int j = 0; j < 4; j++) begin
			jj = 2'(j);
			ia = {2'b00, jj};
			ib = {2'b01, 2'(jj + diag)};
			ic = {2'b10, 2'(jj + {diag[0], 1'b0})};
			id = {2'b11, 2'(jj + {diag[0], diag[0]})};
			t  = '0;
			case (sub_q)
				2'd0: begin
					t          = w_q[ia] + w_q[ib];
					w_step[ia] = t;
					w_step[id] = cc_pkg::rotl32(w_q[id] ^ t, cc_pkg::ROT_A);
				end
				2'd1: begin
					t          = w_q[ic] + w_q[id];
					w_step[ic] = t;
					w_step[ib] = cc_pkg::rotl32(w_q[ib] ^ t, cc_pkg::ROT_B);
				end
				2'd2: begin
					t          = w_q[ia] + w_q[ib];
					w_step[ia] = t;
					w_step[id] = cc_pkg::rotl32(w_q[id] ^ t, cc_pkg::ROT_C);
				end
				default: begin
					t          = w_q[ic] + w_q[id];
					w_step[ic] = t;
					w_step[ib] = cc_pkg::rotl32(w_q[ib] ^ t, cc_pkg::ROT_D);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (blk_req.start) begin
					w_q    <= w_init;
					init_q <= w_init;
				end
			end
			C_RUN: begin
				w_q <= w_step;
			end
			C_FIN: begin
				for (int k = 0; k < 16; k++) begin
					w_q[k] <= w_q[k] + init_q[k];
				end
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			sub_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (blk_req.start) begin
						state_q <= C_RUN;
						round_q <= '0;
						sub_q   <= '0;
					end
				end
				C_RUN: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd3) begin
						if (round_q == cc_pkg::ROUND_W'(cc_pkg::NUM_ROUNDS - 1)) begin
							state_q <= C_FIN;
						end else begin
							round_q <= round_q + 1'b1;
						end
					end
				end
				C_FIN: begin
					state_q <= C_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/cc_back.sv */
module cc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cc_pkg::cc_item_t    q_item,
	output logic                q_pop,
	output cc_pkg::cc_blk_req_t blk_req,
	input  logic                core_done,
	input  cc_pkg::cc_state_t   ks_block,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          out_byte,
	output logic                out_last
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_GEN  = 2'b10
	} back_state_t;

	back_state_t state_q;
	logic [31:0] count_q;
	logic [5:0]  pos_q;
	logic        ready_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        emit;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;

	assign emit    = (state_q == B_IDLE) && q_valid && ready_q && (!out_valid_q || pop);
	assign q_pop   = emit;
	assign ks_word = ks_block[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	assign blk_req.start   = (state_q == B_IDLE) && q_valid && !ready_q;
	assign blk_req.counter = count_q;

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= q_item.data ^ ks_byte;
			out_last_q <= q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (blk_req.start) begin
						state_q <= B_GEN;
					end
					if (emit) begin
						pos_q <= pos_q + 1'b1;
						if (q_item.last) begin
							// end of message: rewind counter and position
							count_q <= '0;
							pos_q   <= '0;
							ready_q <= 1'b0;
						end else if (pos_q == 6'd63) begin
							count_q <= count_q + 1'b1;
							ready_q <= 1'b0;
						end
					end
				end
				B_GEN: begin
					if (core_done) begin
						state_q <= B_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/chacha20_stream_cipher_core.sv */
// An item that needs a fresh keystream block waits at the head of the input queue until
// the block is made; the other 63 items of a block go on to the result register once it is free.
// Items stall while the shared quarter-round unit makes each 64-byte block, which takes
// 80 add/xor/rotate steps plus one final add.
// Reset (arst_n low, asynchronous): queues empty, counter and byte position zero, no block held,
// all key and nonce registers zero.
module chacha20_stream_cipher_core #(
	parameter int unsigned QUEUE_DEPTH = cc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item queue side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_last,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]         key_word0_q;
	logic [63:0]         key_word1_q;
	logic [63:0]         key_word2_q;
	logic [63:0]         key_word3_q;
	logic [63:0]         nonce_lo_q;
	logic [31:0]         nonce_hi_q;

	cc_pkg::cc_item_t    wr_item;
	cc_pkg::cc_item_t    q_item;
	logic                q_valid;
	logic                q_pop;
	cc_pkg::cc_blk_req_t blk_req;
	logic                core_done;
	cc_pkg::cc_state_t   ks_block;
	cc_pkg::cc_key_t     key;
	cc_pkg::cc_nonce_t   nonce;

	// Config registers. The user must write only while the block is idle, so a new key or nonce
	// is picked up by the next block the core starts; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_word0_q <= '0;
			key_word1_q <= '0;
			key_word2_q <= '0;
			key_word3_q <= '0;
			nonce_lo_q  <= '0;
			nonce_hi_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cc_pkg::REG_KEY0:     key_word0_q <= cfg_data;
				cc_pkg::REG_KEY1:     key_word1_q <= cfg_data;
				cc_pkg::REG_KEY2:     key_word2_q <= cfg_data;
				cc_pkg::REG_KEY3:     key_word3_q <= cfg_data;
				cc_pkg::REG_NONCE_LO: nonce_lo_q  <= cfg_data;
				cc_pkg::REG_NONCE_HI: nonce_hi_q  <= cfg_data[31:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Key and nonce words in state order, little-endian within each register.
	assign key   = {key_word3_q, key_word2_q, key_word1_q, key_word0_q};
	assign nonce = {nonce_hi_q, nonce_lo_q};

	assign wr_item.data = in_byte;
	assign wr_item.last = in_last;

	// Front: hold incoming items so the producer keeps pushing while a block is made.
	cc_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.wr_item  (wr_item),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	// Block function: iterates the double rounds on one shared step unit and
	// keeps the finished keystream block until the next start.
	cc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_req  (blk_req),
		.key      (key),
		.nonce    (nonce),
		.done     (core_done),
		.ks_block (ks_block)
	);

	// Back: request blocks on demand, XOR each item with its keystream byte,
	// advance the byte position and counter, and hold the result register.
	cc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.blk_req   (blk_req),
		.core_done (core_done),
		.ks_block  (ks_block),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

`ifndef SYNTHESIS
	// The back never takes an item the front does not have.
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back popped an empty input queue");

	// A block request is a single-cycle pulse: the back waits for the core.
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		blk_req.start |=> !blk_req.start)
		else $error("block start held for more than one cycle");

	// A new request never coincides with the finish of the previous block.
	a_start_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(blk_req.start && core_done))
		else $error("block start while core reports done");

	// The core does not report done too soon after a start.
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		blk_req.start |=> ##1 !core_done)
		else $error("core done too soon after start");
`endif

endmodule
